// ===== hdl/tas_pkg.sv =====
// shared types, widths and codes for the timed action sequencer
package tas_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ENTRY_W     = 4;
  localparam int DELAY_W     = 16;
  localparam int MULT_W      = 16;
  localparam int CD_W        = 32;
  localparam int NUM_W       = 5;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  // entries in use never exceed the table or the 4-bit index range
  localparam logic [NUM_W-1:0] USED_MAX  = (MAX_ENTRIES < 16) ? NUM_W'(MAX_ENTRIES) : 5'd16;
  localparam logic [NUM_W-1:0] FIRE_MAX  = 5'd16;

  localparam logic [2:0] KIND_EVAL    = 3'd0;
  localparam logic [2:0] KIND_TICK    = 3'd1;
  localparam logic [2:0] KIND_ENABLE  = 3'd2;
  localparam logic [2:0] KIND_DISABLE = 3'd3;
  localparam logic [2:0] KIND_WRITE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ACTIONS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_CONT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_IMM    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_MULT    = 2'd3;

  typedef enum logic [1:0] {
    PH_OFF     = 2'd0,
    PH_RUN_NOW = 2'd1,
    PH_WAIT    = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_WALK = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic dec;
  } cd_ctrl_t;

  typedef struct packed {
    logic zero;
    logic one;
  } cd_stat_t;

endpackage

// ===== hdl/tas_delay_table.sv =====
// delay table: one write port, one read port, cleared by reset
module tas_delay_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [tas_pkg::ENTRY_W-1:0]      waddr,
  input  logic [tas_pkg::DELAY_W-1:0]      wdata,
  input  logic [tas_pkg::ENTRY_W-1:0]      raddr,
  output logic [tas_pkg::DELAY_W-1:0]      rdata
);

  logic [tas_pkg::DELAY_W-1:0] entries [tas_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tas_pkg::MAX_ENTRIES; i++) begin
        entries[i] <= '0;
      end
    end else if (we) begin
      entries[waddr] <= wdata;
    end
  end

  assign rdata = entries[raddr];

endmodule

// ===== hdl/tas_countdown.sv =====
// millisecond countdown with the delay times unit multiplier load
module tas_countdown (
  input  logic                        clk,
  input  logic                        rst,
  input  tas_pkg::cd_ctrl_t           ctrl,
  input  logic [tas_pkg::DELAY_W-1:0] delay,
  input  logic [tas_pkg::MULT_W-1:0]  unit_multiplier,
  output logic [tas_pkg::CD_W-1:0]    value,
  output tas_pkg::cd_stat_t           stat
);

  logic [tas_pkg::MULT_W-1:0] unit_eff;
  logic [tas_pkg::CD_W-1:0]   product;
  logic [tas_pkg::CD_W-1:0]   countdown;

  // a zero multiplier counts as one
  assign unit_eff = (unit_multiplier == '0) ? tas_pkg::MULT_W'(1) : unit_multiplier;
  assign product  = tas_pkg::CD_W'(delay) * tas_pkg::CD_W'(unit_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown <= '0;
    end else if (ctrl.clear) begin
      countdown <= '0;
    end else if (ctrl.load) begin
      countdown <= product;
    end else if (ctrl.dec) begin
      countdown <= countdown - tas_pkg::CD_W'(1);
    end
  end

  assign value     = countdown;
  assign stat.zero = (countdown == '0);
  assign stat.one  = (countdown == tas_pkg::CD_W'(1));

endmodule

// ===== hdl/timed_action_sequencer_core.sv =====
// timed action sequencer top level: config registers, sequencer and result stage
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  request  | req_valid / req_ready     | kind, start_active, stop_active, entry_index,
//           |                           | delay_value
//  result   | rsp_valid / rsp_ready     | fire, action_index, waiting, current_entry, last
//  config   | cfg_we                    | cfg_index, cfg_data
//
//  a request is taken while req_ready is high; a restart then scans the table one entry per cycle
//  (at most 16 entries) or an expired entry walks up to 16 entries, one per cycle, both
//  through the single table read port, then the results are emitted one at a time.
//  synchronous reset clears the table, timer and registers to their defaults.
//  req_ready is low from acceptance until the last result of the request is taken;
//  a stalled result holds until rsp_ready.
module timed_action_sequencer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [2:0]                     kind,
  input  logic                           start_active,
  input  logic                           stop_active,
  input  logic [tas_pkg::ENTRY_W-1:0]    entry_index,
  input  logic [tas_pkg::DELAY_W-1:0]    delay_value,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic                           fire,
  output logic [tas_pkg::ENTRY_W-1:0]    action_index,
  output logic                           waiting,
  output logic [tas_pkg::ENTRY_W-1:0]    current_entry,
  output logic                           last,
  input  logic                           cfg_we,
  input  logic [tas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tas_pkg::CFG_W-1:0]      cfg_data
);

  // configuration registers
  logic [tas_pkg::NUM_W-1:0]  num_actions;
  logic                       run_continuously;
  logic                       start_immediately;
  logic [tas_pkg::MULT_W-1:0] unit_multiplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_actions       <= tas_pkg::NUM_W'(1);
      run_continuously  <= 1'b0;
      start_immediately <= 1'b0;
      unit_multiplier   <= tas_pkg::MULT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        tas_pkg::REG_NUM_ACTIONS: num_actions       <= cfg_data[tas_pkg::NUM_W-1:0];
        tas_pkg::REG_RUN_CONT:    run_continuously  <= cfg_data[0];
        tas_pkg::REG_START_IMM:   start_immediately <= cfg_data[0];
        tas_pkg::REG_UNIT_MULT:   unit_multiplier   <= cfg_data[tas_pkg::MULT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  tas_pkg::state_t            state, state_next;
  tas_pkg::phase_t            phase, phase_next;
  logic [tas_pkg::ENTRY_W-1:0] ptr, ptr_next;
  logic [tas_pkg::ENTRY_W-1:0] first, first_next;
  logic [tas_pkg::NUM_W-1:0]   nfire, nfire_next;
  logic [tas_pkg::NUM_W-1:0]   emit_k, emit_k_next;
  logic                        seen, seen_next;
  logic                        listening, listening_next;

  logic [tas_pkg::NUM_W-1:0]   n_used;
  logic [tas_pkg::NUM_W-1:0]   ptr_ext, ptr_inc, first_inc;
  logic                        wrap;
  logic [tas_pkg::ENTRY_W-1:0] nxt;
  logic                        req_fire;
  logic                        rsp_last;

  logic                        tbl_we;
  logic [tas_pkg::ENTRY_W-1:0] tbl_raddr;
  logic [tas_pkg::DELAY_W-1:0] tbl_rdata;
  logic                        rd_nz;

  tas_pkg::cd_ctrl_t           cd_ctrl;
  tas_pkg::cd_stat_t           cd_stat;
  logic [tas_pkg::CD_W-1:0]    cd_value;

  assign n_used    = (num_actions > tas_pkg::USED_MAX) ? tas_pkg::USED_MAX : num_actions;
  assign ptr_ext   = {1'b0, ptr};
  assign ptr_inc   = ptr_ext + tas_pkg::NUM_W'(1);
  assign first_inc = {1'b0, first} + tas_pkg::NUM_W'(1);
  assign wrap      = (ptr_inc >= n_used);
  assign nxt       = wrap ? '0 : ptr_inc[tas_pkg::ENTRY_W-1:0];

  // the walk looks ahead at the entry after the one it fires
  assign tbl_raddr = (state == tas_pkg::ST_WALK) ? nxt : ptr;
  assign rd_nz     = (tbl_rdata != '0);

  assign req_ready = (state == tas_pkg::ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign tbl_we    = req_fire && (kind == tas_pkg::KIND_WRITE) &&
                     (32'(entry_index) < tas_pkg::MAX_ENTRIES);

  assign rsp_last  = (nfire == '0) || (emit_k + tas_pkg::NUM_W'(1) == nfire);

  tas_delay_table u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (tbl_we),
    .waddr (entry_index),
    .wdata (delay_value),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  tas_countdown u_countdown (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (cd_ctrl),
    .delay           (tbl_rdata),
    .unit_multiplier (unit_multiplier),
    .value           (cd_value),
    .stat            (cd_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tas_pkg::ST_IDLE;
      phase     <= tas_pkg::PH_OFF;
      ptr       <= '0;
      first     <= '0;
      nfire     <= '0;
      emit_k    <= '0;
      seen      <= 1'b0;
      listening <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      ptr       <= ptr_next;
      first     <= first_next;
      nfire     <= nfire_next;
      emit_k    <= emit_k_next;
      seen      <= seen_next;
      listening <= listening_next;
    end
  end

  always_comb begin
    logic            eval_go;
    tas_pkg::phase_t phase_pre;
    tas_pkg::phase_t ph;

    eval_go        = 1'b0;
    phase_pre      = phase;
    ph             = phase;
    state_next     = state;
    phase_next     = phase;
    ptr_next       = ptr;
    first_next     = first;
    nfire_next     = nfire;
    emit_k_next    = emit_k;
    seen_next      = seen;
    listening_next = listening;
    cd_ctrl        = '0;

    case (state)
      tas_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_next  = tas_pkg::ST_EMIT;
          nfire_next  = '0;
          emit_k_next = '0;
          case (kind)
            tas_pkg::KIND_EVAL: begin
              eval_go = 1'b1;
            end
            tas_pkg::KIND_TICK: begin
              if (phase == tas_pkg::PH_WAIT && !cd_stat.zero) begin
                cd_ctrl.dec = 1'b1;
                if (cd_stat.one) begin
                  phase_pre = tas_pkg::PH_DONE;
                  eval_go   = 1'b1;
                end
              end
            end
            tas_pkg::KIND_ENABLE: begin
              if (!listening) begin
                listening_next = 1'b1;
                if (start_immediately || phase != tas_pkg::PH_OFF) begin
                  if (phase == tas_pkg::PH_OFF) phase_pre = tas_pkg::PH_RUN_NOW;
                  eval_go = 1'b1;
                end
              end
            end
            tas_pkg::KIND_DISABLE: begin
              cd_ctrl.clear  = 1'b1;
              phase_next     = tas_pkg::PH_OFF;
              listening_next = 1'b0;
            end
            default: ;
          endcase

          if (eval_go) begin
            if (stop_active) begin
              cd_ctrl.clear = 1'b1;
              phase_next    = tas_pkg::PH_OFF;
            end else begin
              seen_next = start_active;
              ph = (start_active && !seen) ? tas_pkg::PH_RUN_NOW : phase_pre;
              if (ph == tas_pkg::PH_RUN_NOW) begin
                cd_ctrl.clear = 1'b1;
                ptr_next      = '0;
                phase_next    = tas_pkg::PH_RUN_NOW;
                state_next    = tas_pkg::ST_SCAN;
              end else if (ph == tas_pkg::PH_DONE) begin
                if (ptr_ext >= n_used) begin
                  // table shrank under a running countdown
                  ptr_next   = '0;
                  phase_next = tas_pkg::PH_OFF;
                end else begin
                  first_next = ptr;
                  phase_next = tas_pkg::PH_DONE;
                  state_next = tas_pkg::ST_WALK;
                end
              end else begin
                phase_next = ph;
              end
            end
          end
        end
      end

      tas_pkg::ST_SCAN: begin
        if (ptr_ext >= n_used) begin
          ptr_next   = '0;
          phase_next = tas_pkg::PH_OFF;
          state_next = tas_pkg::ST_EMIT;
        end else if (rd_nz) begin
          cd_ctrl.load = 1'b1;
          phase_next   = tas_pkg::PH_WAIT;
          state_next   = tas_pkg::ST_EMIT;
        end else if (ptr_inc >= n_used) begin
          ptr_next   = '0;
          phase_next = tas_pkg::PH_OFF;
          state_next = tas_pkg::ST_EMIT;
        end else begin
          ptr_next = ptr_inc[tas_pkg::ENTRY_W-1:0];
        end
      end

      tas_pkg::ST_WALK: begin
        nfire_next = nfire + tas_pkg::NUM_W'(1);
        if (wrap && !run_continuously) begin
          ptr_next   = '0;
          phase_next = tas_pkg::PH_OFF;
          state_next = tas_pkg::ST_EMIT;
        end else begin
          ptr_next = nxt;
          if (rd_nz) begin
            cd_ctrl.load = 1'b1;
            phase_next   = tas_pkg::PH_WAIT;
            state_next   = tas_pkg::ST_EMIT;
          end else if (nxt == first || nfire_next == tas_pkg::FIRE_MAX) begin
            // went all the way round through zero delays
            phase_next = tas_pkg::PH_OFF;
            state_next = tas_pkg::ST_EMIT;
          end
        end
      end

      tas_pkg::ST_EMIT: begin
        if (rsp_ready) begin
          if (rsp_last) begin
            state_next = tas_pkg::ST_IDLE;
          end else begin
            emit_k_next = emit_k + tas_pkg::NUM_W'(1);
            first_next  = (first_inc >= n_used) ? '0 : first_inc[tas_pkg::ENTRY_W-1:0];
          end
        end
      end

      default: begin
        state_next = tas_pkg::ST_IDLE;
      end
    endcase
  end

  // first doubles as the index of the action being reported
  assign rsp_valid     = (state == tas_pkg::ST_EMIT);
  assign fire          = (nfire != '0);
  assign action_index  = fire ? first : '0;
  assign waiting       = (phase == tas_pkg::PH_WAIT);
  assign current_entry = ptr;
  assign last          = rsp_last;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken while results pending");

  a_phase_settled: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (phase == tas_pkg::PH_OFF || phase == tas_pkg::PH_WAIT))
    else $error("result shown with unresolved timer phase");

  a_fire_in_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && fire) |-> ({1'b0, action_index} < n_used))
    else $error("fired action outside entries in use");

  a_wait_counts: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && waiting) |-> (cd_value != '0))
    else $error("waiting with an empty countdown");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tas_pkg::ST_WALK) |-> (nfire < tas_pkg::FIRE_MAX))
    else $error("walk fired past its limit");

endmodule
